// ===== hw/rtl/dbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth back-projection package
// Shared widths, register indexes, reset values and the command and status
// types that join the controller and the datapath.
// ----------------------------------------------------------------------------
package dbp_pkg;

  localparam int MAX_DIM_DEF = 4096;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIM_CFG_W  = 13;
  localparam int CENTER_W   = 16;
  localparam int INV_W      = 24;
  localparam int DEPTH_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int PACKED_W   = 3 * COLOR_W;
  localparam int POS_W      = 32;
  localparam int Z_W        = 20;
  localparam int FRAC_SHIFT = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd5;

  localparam logic [DIM_CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [DIM_CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [CENTER_W-1:0]  CENTER_X_RST     = 16'd5120;
  localparam logic [CENTER_W-1:0]  CENTER_Y_RST     = 16'd3840;
  localparam logic [INV_W-1:0]     INV_FOCAL_X_RST  = 24'd32263;
  localparam logic [INV_W-1:0]     INV_FOCAL_Y_RST  = 24'd32263;

  typedef struct packed {
    logic [DIM_CFG_W-1:0] frame_width;
    logic [DIM_CFG_W-1:0] frame_height;
    logic [CENTER_W-1:0]  center_x_q4;
    logic [CENTER_W-1:0]  center_y_q4;
    logic [INV_W-1:0]     inv_focal_x_q24;
    logic [INV_W-1:0]     inv_focal_y_q24;
  } dbp_cfg_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_MAG_DEPTH,
    MUL_T_LO,
    MUL_T_HI
  } dbp_mul_sel_e;

  typedef struct packed {
    logic         in_ready;
    logic         load;
    logic         mul_en;
    dbp_mul_sel_e mul_sel;
    logic         acc_load;
    logic         acc_add;
    logic         rnd;
    logic         axis;
    logic         out_load;
  } dbp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } dbp_status_t;

endpackage

// ===== hw/rtl/dbp_pixel_if.sv =====
// ----------------------------------------------------------------------------
// Depth pixel channel
// Valid/ready channel carrying one depth sample and its three color bytes.
// ----------------------------------------------------------------------------
interface dbp_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [dbp_pkg::DEPTH_W-1:0] depth_mm;
  logic [dbp_pkg::COLOR_W-1:0] first_color;
  logic [dbp_pkg::COLOR_W-1:0] second_color;
  logic [dbp_pkg::COLOR_W-1:0] third_color;

  modport source (
    output valid, depth_mm, first_color, second_color, third_color,
    input  ready
  );
  modport sink (
    input  valid, depth_mm, first_color, second_color, third_color,
    output ready
  );
endinterface

// ===== hw/rtl/dbp_point_if.sv =====
// ----------------------------------------------------------------------------
// Point channel
// Valid/ready channel carrying one back-projected point with its color.
// ----------------------------------------------------------------------------
interface dbp_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [dbp_pkg::POS_W-1:0]    x_pos;
  logic signed [dbp_pkg::POS_W-1:0]    y_pos;
  logic        [dbp_pkg::Z_W-1:0]      z_pos;
  logic                                point_valid;
  logic        [dbp_pkg::PACKED_W-1:0] packed_color;
  logic                                last_of_frame;

  modport source (
    output valid, x_pos, y_pos, z_pos, point_valid, packed_color, last_of_frame,
    input  ready
  );
  modport sink (
    input  valid, x_pos, y_pos, z_pos, point_valid, packed_color, last_of_frame,
    output ready
  );
endinterface

// ===== hw/rtl/depth_to_point_backprojection_unit.sv =====
// ----------------------------------------------------------------------------
// Depth to point back-projection unit
// Back-projects a raster stream of depth pixels through a pinhole camera
// model into points with packed color.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake    Payload
//  pix_i     in   valid/ready  depth_mm, first/second/third_color
//  pt_o      out  valid/ready  x_pos, y_pos, z_pos, point_valid,
//                              packed_color, last_of_frame
//  cfg_*_i   in   write enable register index, 24-bit write data
//
//  One 16 by 24 bit multiplier is used three times per axis, x then y,
//  each followed by accumulate and round, before the point is loaded
//  into the output register. Intake reopens after that hand-off, so no
//  new pixel is taken while one is in flight. A stalled output delays
//  intake only while the output register is still occupied at hand-off.
//  Reset clears the raster counters and loads the default camera registers.
//
module depth_to_point_backprojection_unit #(
  parameter int MAX_DIM = dbp_pkg::MAX_DIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dbp_pixel_if.sink                      pix_i,
  dbp_point_if.source                    pt_o,
  input  logic                           cfg_we_i,
  input  logic [dbp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dbp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  dbp_pkg::dbp_cfg_t    cfg_q;
  dbp_pkg::dbp_cmd_t    cmd;
  dbp_pkg::dbp_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width     <= dbp_pkg::FRAME_WIDTH_RST;
      cfg_q.frame_height    <= dbp_pkg::FRAME_HEIGHT_RST;
      cfg_q.center_x_q4     <= dbp_pkg::CENTER_X_RST;
      cfg_q.center_y_q4     <= dbp_pkg::CENTER_Y_RST;
      cfg_q.inv_focal_x_q24 <= dbp_pkg::INV_FOCAL_X_RST;
      cfg_q.inv_focal_y_q24 <= dbp_pkg::INV_FOCAL_Y_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dbp_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= dbp_pkg::DIM_CFG_W'(cfg_data_i);
        dbp_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= dbp_pkg::DIM_CFG_W'(cfg_data_i);
        dbp_pkg::REG_CENTER_X:     cfg_q.center_x_q4  <= dbp_pkg::CENTER_W'(cfg_data_i);
        dbp_pkg::REG_CENTER_Y:     cfg_q.center_y_q4  <= dbp_pkg::CENTER_W'(cfg_data_i);
        dbp_pkg::REG_INV_FOCAL_X:  cfg_q.inv_focal_x_q24 <= cfg_data_i;
        dbp_pkg::REG_INV_FOCAL_Y:  cfg_q.inv_focal_y_q24 <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  dbp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  dbp_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cmd_i    (cmd),
    .status_o (status),
    .pix      (pix_i),
    .pt       (pt_o)
  );

endmodule

// ===== hw/rtl/dbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Back-projection controller
// Sequences one pixel through the shared multiplier, once per axis, then
// hands the finished point to the output register.
// ----------------------------------------------------------------------------
module dbp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dbp_pkg::dbp_status_t status_i,
  output dbp_pkg::dbp_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MT   = 3'd1;
  localparam logic [2:0] S_ML   = 3'd2;
  localparam logic [2:0] S_MH   = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_RND  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       axis_q, axis_d;

  always_comb begin
    state_d        = state_q;
    axis_d         = axis_q;
    cmd_o          = '0;
    cmd_o.axis     = axis_q;
    cmd_o.mul_sel  = dbp_pkg::MUL_MAG_DEPTH;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          cmd_o.load = 1'b1;
          axis_d     = 1'b0;
          state_d    = S_MT;
        end
      end
      S_MT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = dbp_pkg::MUL_MAG_DEPTH;
        state_d       = S_ML;
      end
      S_ML: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = dbp_pkg::MUL_T_LO;
        state_d       = S_MH;
      end
      S_MH: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = dbp_pkg::MUL_T_HI;
        cmd_o.acc_load = 1'b1;
        state_d        = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_RND;
      end
      S_RND: begin
        cmd_o.rnd = 1'b1;
        if (axis_q) begin
          state_d = S_OUT;
        end else begin
          axis_d  = 1'b1;
          state_d = S_MT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  a_load_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_MT) && !axis_q)
    else $error("accepted pixel did not start the x axis");

  a_out_after_both_axes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> axis_q)
    else $error("point handed out before the y axis was done");

  a_single_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.acc_add, cmd_o.rnd, cmd_o.out_load}))
    else $error("more than one datapath phase in a cycle");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("output register overwritten while a point waits");

endmodule

// ===== hw/rtl/dbp_datapath.sv =====
// ----------------------------------------------------------------------------
// Back-projection datapath
// Raster counters, offset magnitudes, one shared multiplier with its
// accumulator, rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module dbp_datapath #(
  parameter int MAX_DIM = dbp_pkg::MAX_DIM_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dbp_pkg::dbp_cfg_t    cfg_i,
  input  dbp_pkg::dbp_cmd_t    cmd_i,
  output dbp_pkg::dbp_status_t status_o,
  dbp_pixel_if.sink            pix,
  dbp_point_if.source          pt
);

  localparam int CNT_W  = $clog2(MAX_DIM);
  localparam int CMP_W  = (CNT_W + 1 > dbp_pkg::DIM_CFG_W) ? CNT_W + 1 : dbp_pkg::DIM_CFG_W;
  localparam int MAG_W  = (CNT_W + 4 > dbp_pkg::CENTER_W) ? CNT_W + 4 : dbp_pkg::CENTER_W;
  localparam int B_W    = dbp_pkg::INV_W;
  localparam int PROD_W = MAG_W + B_W;
  localparam int T_W    = MAG_W + dbp_pkg::DEPTH_W;
  localparam int LO_W   = T_W / 2;
  localparam int HI_W   = T_W - LO_W;
  localparam int ACC_W  = T_W + B_W;
  localparam int Q_W    = ACC_W - dbp_pkg::FRAC_SHIFT;
  localparam int PW     = dbp_pkg::POS_W;

  // Raster position.
  logic [CNT_W-1:0] col_q, row_q;
  logic [CMP_W-1:0] eff_w, eff_h, col_inc, row_inc;
  logic             row_end, frame_end;

  // Per-pixel operands.
  logic [dbp_pkg::DEPTH_W-1:0]  depth_q;
  logic [dbp_pkg::PACKED_W-1:0] color_q;
  logic                         last_q;
  logic [MAG_W-1:0]             mag_x_d, mag_y_d, mag_x_q, mag_y_q;
  logic                         neg_x_d, neg_y_d, neg_x_q, neg_y_q;
  logic [MAG_W:0]               p16_x, p16_y, c_x, c_y;

  // Multiplier and accumulator.
  logic [MAG_W-1:0]  mul_a;
  logic [B_W-1:0]    mul_b, inv_sel;
  logic [PROD_W-1:0] mul_res, prod_q;
  logic [HI_W-1:0]   t_hi_q;
  logic [ACC_W-1:0]  acc_q, rnd_sum;
  logic [Q_W-1:0]    q_mag;
  logic [PW-1:0]     q_sat, pos_res;
  logic              neg_sel;
  logic [PW-1:0]     x_q, y_q;

  // Output register.
  logic                         full_q;
  logic [PW-1:0]                out_x_q, out_y_q;
  logic [dbp_pkg::Z_W-1:0]      out_z_q;
  logic                         out_valid_q, out_last_q;
  logic [dbp_pkg::PACKED_W-1:0] out_color_q;

  // Frame sizes of zero act as one; sizes above the counter range clamp.
  always_comb begin
    eff_w = CMP_W'(cfg_i.frame_width);
    if (eff_w == '0) begin
      eff_w = CMP_W'(1);
    end else if (eff_w > CMP_W'(MAX_DIM)) begin
      eff_w = CMP_W'(MAX_DIM);
    end
    eff_h = CMP_W'(cfg_i.frame_height);
    if (eff_h == '0) begin
      eff_h = CMP_W'(1);
    end else if (eff_h > CMP_W'(MAX_DIM)) begin
      eff_h = CMP_W'(MAX_DIM);
    end
    col_inc   = CMP_W'(col_q) + CMP_W'(1);
    row_inc   = CMP_W'(row_q) + CMP_W'(1);
    row_end   = col_inc >= eff_w;
    frame_end = row_end && (row_inc >= eff_h);
  end

  // Offset from the principal point as sign and magnitude, Q4 pixels.
  always_comb begin
    p16_x   = (MAG_W + 1)'({col_q, 4'b0000});
    p16_y   = (MAG_W + 1)'({row_q, 4'b0000});
    c_x     = (MAG_W + 1)'(cfg_i.center_x_q4);
    c_y     = (MAG_W + 1)'(cfg_i.center_y_q4);
    neg_x_d = p16_x < c_x;
    neg_y_d = p16_y < c_y;
    mag_x_d = neg_x_d ? MAG_W'(c_x - p16_x) : MAG_W'(p16_x - c_x);
    mag_y_d = neg_y_d ? MAG_W'(c_y - p16_y) : MAG_W'(p16_y - c_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.load) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= frame_end ? '0 : CNT_W'(row_inc);
      end else begin
        col_q <= CNT_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      depth_q <= pix.depth_mm;
      color_q <= {pix.first_color, pix.second_color, pix.third_color};
      last_q  <= frame_end;
      mag_x_q <= mag_x_d;
      mag_y_q <= mag_y_d;
      neg_x_q <= neg_x_d;
      neg_y_q <= neg_y_d;
    end
  end

  // The product mag * depth * inv is built as t = mag * depth, then
  // t_lo * inv + (t_hi * inv << LO_W), one multiplication per cycle.
  always_comb begin
    inv_sel = cmd_i.axis ? cfg_i.inv_focal_y_q24 : cfg_i.inv_focal_x_q24;
    case (cmd_i.mul_sel)
      dbp_pkg::MUL_MAG_DEPTH: begin
        mul_a = cmd_i.axis ? mag_y_q : mag_x_q;
        mul_b = B_W'(depth_q);
      end
      dbp_pkg::MUL_T_LO: begin
        mul_a = MAG_W'(prod_q[LO_W-1:0]);
        mul_b = inv_sel;
      end
      dbp_pkg::MUL_T_HI: begin
        mul_a = MAG_W'(t_hi_q);
        mul_b = inv_sel;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_res = {{B_W{1'b0}}, mul_a} * {{MAG_W{1'b0}}, mul_b};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_res;
    end
    if (cmd_i.mul_en && cmd_i.mul_sel == dbp_pkg::MUL_T_LO) begin
      t_hi_q <= prod_q[T_W-1:LO_W];
    end
    if (cmd_i.acc_load) begin
      acc_q <= ACC_W'(prod_q);
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + (ACC_W'(prod_q) << LO_W);
    end
  end

  // Round half away from zero on the magnitude, then apply the sign and
  // saturate to the signed 32-bit range.
  always_comb begin
    rnd_sum = acc_q + (ACC_W'(1) << (dbp_pkg::FRAC_SHIFT - 1));
    q_mag   = rnd_sum[ACC_W-1:dbp_pkg::FRAC_SHIFT];
    neg_sel = cmd_i.axis ? neg_y_q : neg_x_q;
    if (neg_sel) begin
      q_sat   = (q_mag > Q_W'(64'h8000_0000)) ? 32'h8000_0000 : q_mag[PW-1:0];
      pos_res = 32'd0 - q_sat;
    end else begin
      q_sat   = (q_mag > Q_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_mag[PW-1:0];
      pos_res = q_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rnd) begin
      if (cmd_i.axis) begin
        y_q <= pos_res;
      end else begin
        x_q <= pos_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      full_q <= 1'b1;
    end else if (pt.ready) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_valid_q <= depth_q != '0;
      out_x_q     <= (depth_q != '0) ? x_q : '0;
      out_y_q     <= (depth_q != '0) ? y_q : '0;
      out_z_q     <= {depth_q, 4'b0000};
      out_color_q <= color_q;
      out_last_q  <= last_q;
    end
  end

  assign pix.ready          = cmd_i.in_ready;
  assign status_o.in_valid  = pix.valid;
  assign status_o.out_free  = !full_q || pt.ready;

  assign pt.valid         = full_q;
  assign pt.x_pos         = out_x_q;
  assign pt.y_pos         = out_y_q;
  assign pt.z_pos         = out_z_q;
  assign pt.point_valid   = out_valid_q;
  assign pt.packed_color  = out_color_q;
  assign pt.last_of_frame = out_last_q;

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(col_q) < CMP_W'(MAX_DIM) && CMP_W'(row_q) < CMP_W'(MAX_DIM))
    else $error("raster counter beyond the largest frame");

  a_wrap_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && frame_end |=> col_q == '0 && row_q == '0)
    else $error("counters did not wrap after the last pixel of a frame");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q && !pt.ready |-> !cmd_i.out_load)
    else $error("stalled point overwritten");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth to point back-projection unit testbench
// Streams raster depth pixels through the unit under random sender bursts and
// receiver stalls. Each pixel is back-projected by an in-bench model that
// tracks its own raster counters and camera registers. Each point is checked
// field by field in order. Runs cover register extremes, frame wrap,
// saturation, invalid depth and frame size changes mid-frame.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 16;

  // Indexes past the last register; writes to them must be ignored.
  localparam logic [dbp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [dbp_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_SPARSE,
    RDY_PERIODIC
  } ready_mode_e;

  typedef struct packed {
    logic [dbp_pkg::DEPTH_W-1:0] depth_mm;
    logic [dbp_pkg::COLOR_W-1:0] first_color;
    logic [dbp_pkg::COLOR_W-1:0] second_color;
    logic [dbp_pkg::COLOR_W-1:0] third_color;
  } pixel_t;

  typedef struct packed {
    logic signed [dbp_pkg::POS_W-1:0] x_pos;
    logic signed [dbp_pkg::POS_W-1:0] y_pos;
    logic [dbp_pkg::Z_W-1:0]          z_pos;
    logic                             point_valid;
    logic [dbp_pkg::PACKED_W-1:0]     packed_color;
    logic                             last_of_frame;
  } point_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [dbp_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [dbp_pkg::CFG_DATA_W-1:0] cfg_data_i;

  dbp_pixel_if pix ();
  dbp_point_if pt ();

  depth_to_point_backprojection_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix),
    .pt_o       (pt),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  pixel_t            pending_pixels[$];
  point_t            expected_points[$];
  dbp_pkg::dbp_cfg_t camera_regs;
  logic [11:0]       raster_col;
  logic [11:0]       raster_row;
  int                mismatches;
  int                burst_left;
  int                gap_left;
  int                ready_run;
  ready_mode_e       ready_mode;
  int                idle_cycles;
  pixel_t            drive_pixel;
  point_t            oldest_point;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int frame_dim(logic [dbp_pkg::DIM_CFG_W-1:0] setting);
    if (setting == '0) return 1;
    if (setting > dbp_pkg::MAX_DIM_DEF) return dbp_pkg::MAX_DIM_DEF;
    return int'(setting);
  endfunction

  // Signed Q4 offset times depth times Q0.24 reciprocal, rounded half away
  // from zero to Q4 and saturated to 32 bits.
  function automatic logic [dbp_pkg::POS_W-1:0] project_axis(
      logic [11:0] pos, logic [dbp_pkg::CENTER_W-1:0] center,
      logic [dbp_pkg::DEPTH_W-1:0] depth, logic [dbp_pkg::INV_W-1:0] inv);
    logic [16:0] scaled;
    logic [16:0] mag;
    logic        neg;
    logic [63:0] prod;
    logic [63:0] rounded;
    scaled  = {1'b0, pos, 4'b0000};
    neg     = scaled < {1'b0, center};
    mag     = neg ? ({1'b0, center} - scaled) : (scaled - {1'b0, center});
    prod    = 64'(mag) * 64'(depth) * 64'(inv);
    rounded = (prod + (64'd1 << 23)) >> dbp_pkg::FRAC_SHIFT;
    if (neg) begin
      if (rounded > 64'h8000_0000) rounded = 64'h8000_0000;
      rounded = 64'd0 - rounded;
    end else if (rounded > 64'h7FFF_FFFF) begin
      rounded = 64'h7FFF_FFFF;
    end
    return rounded[dbp_pkg::POS_W-1:0];
  endfunction

  function automatic point_t backproject_pixel(pixel_t px);
    point_t pnt;
    int     width;
    int     height;
    logic   row_end;
    logic   frame_end;
    width     = frame_dim(camera_regs.frame_width);
    height    = frame_dim(camera_regs.frame_height);
    row_end   = (int'(raster_col) + 1) >= width;
    frame_end = row_end && ((int'(raster_row) + 1) >= height);
    if (px.depth_mm != '0) begin
      pnt.x_pos = project_axis(raster_col, camera_regs.center_x_q4, px.depth_mm,
                               camera_regs.inv_focal_x_q24);
      pnt.y_pos = project_axis(raster_row, camera_regs.center_y_q4, px.depth_mm,
                               camera_regs.inv_focal_y_q24);
      pnt.z_pos = {px.depth_mm, 4'b0000};
      pnt.point_valid = 1'b1;
    end else begin
      pnt.x_pos = '0;
      pnt.y_pos = '0;
      pnt.z_pos = '0;
      pnt.point_valid = 1'b0;
    end
    pnt.packed_color  = {px.first_color, px.second_color, px.third_color};
    pnt.last_of_frame = frame_end;
    if (row_end) begin
      raster_col = '0;
      raster_row = frame_end ? 12'd0 : raster_row + 12'd1;
    end else begin
      raster_col = raster_col + 12'd1;
    end
    return pnt;
  endfunction

  function automatic void check_field(string name, logic [dbp_pkg::POS_W-1:0] want,
                                      logic [dbp_pkg::POS_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix.valid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!pix.valid || pix.ready) begin
      if (gap_left != 0) begin
        gap_left  <= gap_left - 1;
        pix.valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        drive_pixel = pending_pixels.pop_front();
        pix.valid        <= 1'b1;
        pix.depth_mm     <= drive_pixel.depth_mm;
        pix.first_color  <= drive_pixel.first_color;
        pix.second_color <= drive_pixel.second_color;
        pix.third_color  <= drive_pixel.third_color;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches to a random mode after each run of random length.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pt.ready  <= 1'b0;
      ready_run <= 0;
    end else if (ready_run == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      ready_run  <= $urandom_range(8, 200);
      pt.ready   <= 1'b1;
    end else begin
      ready_run <= ready_run - 1;
      case (ready_mode)
        RDY_ALWAYS:   pt.ready <= 1'b1;
        RDY_RANDOM:   pt.ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE:   pt.ready <= ($urandom_range(0, 7) == 0);
        default:      pt.ready <= (ready_run[4:3] != 2'b00);
      endcase
    end
  end

  // Point check first, then predict the pixel taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pt.valid && pt.ready) begin
        if (expected_points.size() == 0) begin
          $error("point transfer with no pixel outstanding");
          mismatches++;
        end else begin
          oldest_point = expected_points.pop_front();
          check_field("x_pos", oldest_point.x_pos, pt.x_pos);
          check_field("y_pos", oldest_point.y_pos, pt.y_pos);
          check_field("z_pos", 32'(oldest_point.z_pos), 32'(pt.z_pos));
          check_field("point_valid", 32'(oldest_point.point_valid), 32'(pt.point_valid));
          check_field("packed_color", 32'(oldest_point.packed_color),
                      32'(pt.packed_color));
          check_field("last_of_frame", 32'(oldest_point.last_of_frame),
                      32'(pt.last_of_frame));
        end
      end
      if (pix.valid && pix.ready) begin
        expected_points.push_back(backproject_pixel({pix.depth_mm, pix.first_color,
                                                     pix.second_color, pix.third_color}));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (pt.valid && pt.ready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [dbp_pkg::CFG_IDX_W-1:0] idx,
                           logic [dbp_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      dbp_pkg::REG_FRAME_WIDTH:
        camera_regs.frame_width = data[dbp_pkg::DIM_CFG_W-1:0];
      dbp_pkg::REG_FRAME_HEIGHT:
        camera_regs.frame_height = data[dbp_pkg::DIM_CFG_W-1:0];
      dbp_pkg::REG_CENTER_X:
        camera_regs.center_x_q4 = data[dbp_pkg::CENTER_W-1:0];
      dbp_pkg::REG_CENTER_Y:
        camera_regs.center_y_q4 = data[dbp_pkg::CENTER_W-1:0];
      dbp_pkg::REG_INV_FOCAL_X:
        camera_regs.inv_focal_x_q24 = data[dbp_pkg::INV_W-1:0];
      dbp_pkg::REG_INV_FOCAL_Y:
        camera_regs.inv_focal_y_q24 = data[dbp_pkg::INV_W-1:0];
      default: ;
    endcase
  endtask

  task automatic finish_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold off until every pixel has been taken and every point has come out.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_pixels.size() != 0 || pix.valid || expected_points.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic push_pixel(logic [dbp_pkg::DEPTH_W-1:0] depth,
                            logic [dbp_pkg::COLOR_W-1:0] c0,
                            logic [dbp_pkg::COLOR_W-1:0] c1,
                            logic [dbp_pkg::COLOR_W-1:0] c2);
    pending_pixels.push_back({depth, c0, c1, c2});
  endtask

  // Deep pixels keep the depth close to full scale so the products stay wide.
  task automatic push_random_pixels(int count, bit deep);
    logic [dbp_pkg::DEPTH_W-1:0] depth;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0:       depth = '0;
        1:       depth = '1;
        2:       depth = $urandom_range(1, 255);
        default: depth = deep ? 16'(16'hFFFF - $urandom_range(0, 1023)) : 16'($urandom);
      endcase
      push_pixel(depth, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  function automatic logic [dbp_pkg::CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 24'd0;
      1:       return 24'd1;
      2:       return 24'($urandom_range(dbp_pkg::MAX_DIM_DEF + 1, 8191));
      3:       return 24'(dbp_pkg::MAX_DIM_DEF);
      4:       return 24'($urandom);
      default: return 24'($urandom_range(2, 24));
    endcase
  endfunction

  function automatic logic [dbp_pkg::CFG_DATA_W-1:0] pick_center();
    case ($urandom_range(0, 5))
      0:       return {8'($urandom), 16'h0000};
      1:       return {8'($urandom), 16'hFFFF};
      2:       return 24'($urandom);
      default: return 24'($urandom_range(0, 16 * 30));
    endcase
  endfunction

  function automatic logic [dbp_pkg::CFG_DATA_W-1:0] pick_inv_focal();
    case ($urandom_range(0, 5))
      0:       return 24'd0;
      1:       return 24'hFFFFFF;
      2:       return 24'($urandom);
      default: return 24'($urandom_range(8000, 90000));
    endcase
  endfunction

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    pix.valid        = 1'b0;
    pix.depth_mm     = '0;
    pix.first_color  = '0;
    pix.second_color = '0;
    pix.third_color  = '0;
    pt.ready         = 1'b0;
    mismatches       = 0;
    idle_cycles      = 0;
    ready_mode       = RDY_ALWAYS;
    raster_col       = '0;
    raster_row       = '0;
    camera_regs.frame_width     = dbp_pkg::FRAME_WIDTH_RST;
    camera_regs.frame_height    = dbp_pkg::FRAME_HEIGHT_RST;
    camera_regs.center_x_q4     = dbp_pkg::CENTER_X_RST;
    camera_regs.center_y_q4     = dbp_pkg::CENTER_Y_RST;
    camera_regs.inv_focal_x_q24 = dbp_pkg::INV_FOCAL_X_RST;
    camera_regs.inv_focal_y_q24 = dbp_pkg::INV_FOCAL_Y_RST;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default camera: invalid depth, depth extremes and color bit patterns.
    push_pixel(16'h0000, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(16'hFFFF, 8'h00, 8'h00, 8'h00);
    push_pixel(16'h0001, 8'hAA, 8'h55, 8'hAA);
    push_pixel(16'hFFFF, 8'h55, 8'hAA, 8'h55);
    push_pixel(16'h8000, 8'h01, 8'h80, 8'h7F);
    push_pixel(16'h7FFF, 8'hFE, 8'h7F, 8'h80);
    wait_idle();

    // Zero width acts as one, so the column counter left mid-row wraps at once.
    // A far principal column drives x to negative saturation.
    write_reg(REG_UNMAPPED_LO, 24'hFFFFFF);
    write_reg(REG_UNMAPPED_HI, 24'h000000);
    write_reg(dbp_pkg::REG_FRAME_WIDTH, 24'd0);
    write_reg(dbp_pkg::REG_FRAME_HEIGHT, 24'd3);
    write_reg(dbp_pkg::REG_CENTER_X, 24'h00FFFF);
    write_reg(dbp_pkg::REG_CENTER_Y, 24'h000000);
    write_reg(dbp_pkg::REG_INV_FOCAL_X, 24'hFFFFFF);
    write_reg(dbp_pkg::REG_INV_FOCAL_Y, 24'h000000);
    finish_writes();
    push_pixel(16'hFFFF, 8'h12, 8'h34, 8'h56);
    push_pixel(16'h0000, 8'h9A, 8'hBC, 8'hDE);
    push_pixel(16'hFFFF, 8'hFF, 8'h00, 8'hFF);
    push_pixel(16'h0001, 8'h00, 8'hFF, 8'h00);
    push_pixel(16'hFFFF, 8'hC3, 8'h3C, 8'h81);
    wait_idle();

    // Register data above the register width is dropped.
    write_reg(dbp_pkg::REG_FRAME_WIDTH, 24'hFFE003);
    write_reg(dbp_pkg::REG_FRAME_HEIGHT, 24'hFFE002);
    write_reg(dbp_pkg::REG_CENTER_X, 24'hFF0000);
    write_reg(dbp_pkg::REG_CENTER_Y, 24'h00FFFF);
    write_reg(dbp_pkg::REG_INV_FOCAL_X, 24'h000000);
    write_reg(dbp_pkg::REG_INV_FOCAL_Y, 24'hFFFFFF);
    finish_writes();
    push_pixel(16'hFFFF, 8'h01, 8'h02, 8'h04);
    push_pixel(16'hFFFF, 8'h08, 8'h10, 8'h20);
    push_pixel(16'h0000, 8'h40, 8'h80, 8'h00);
    push_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(16'h00FF, 8'h00, 8'h00, 8'h00);
    push_pixel(16'hFF00, 8'h7F, 8'hF7, 8'h77);
    push_pixel(16'hFFFF, 8'hEE, 8'hDD, 8'hCC);
    wait_idle();

    // One pixel per row up a tall frame with the largest vertical reciprocal.
    // A height above the maximum must act as the maximum.
    write_reg(dbp_pkg::REG_FRAME_WIDTH, 24'd1);
    write_reg(dbp_pkg::REG_FRAME_HEIGHT, 24'(dbp_pkg::MAX_DIM_DEF + 1));
    write_reg(dbp_pkg::REG_CENTER_X, pick_center());
    write_reg(dbp_pkg::REG_CENTER_Y, 24'd0);
    write_reg(dbp_pkg::REG_INV_FOCAL_X, pick_inv_focal());
    write_reg(dbp_pkg::REG_INV_FOCAL_Y, 24'hFFFFFF);
    finish_writes();
    push_random_pixels(400, 1'b1);
    wait_idle();

    // Shrinking the height mid-frame ends the frame at the next pixel.
    write_reg(dbp_pkg::REG_FRAME_HEIGHT, 24'd5);
    finish_writes();
    push_random_pixels(12, 1'b0);
    wait_idle();

    repeat (12) begin
      write_reg(dbp_pkg::REG_FRAME_WIDTH, pick_dim());
      write_reg(dbp_pkg::REG_FRAME_HEIGHT, pick_dim());
      write_reg(dbp_pkg::REG_CENTER_X, pick_center());
      write_reg(dbp_pkg::REG_CENTER_Y, pick_center());
      write_reg(dbp_pkg::REG_INV_FOCAL_X, pick_inv_focal());
      write_reg(dbp_pkg::REG_INV_FOCAL_Y, pick_inv_focal());
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI, 24'($urandom));
      end
      finish_writes();
      push_random_pixels($urandom_range(50, 110), $urandom_range(0, 3) == 0);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
